// File: sv/imuamv_pkg.sv
// Shared types and constants for the acceleration magnitude / velocity block.
// No dependencies.
package imuamv_pkg;

  localparam int unsigned ACC_W       = 16;  // one axis sample, signed Q7.8
  localparam int unsigned MAG_W       = 17;  // corrected magnitude, mean, velocity
  localparam int unsigned GRAV_W      = 13;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned SQ_W        = 32;  // sum of three squares
  localparam int unsigned ROOT_W      = 16;
  localparam int unsigned RREM_W      = ROOT_W + 2;
  localparam int unsigned ROOT_STEPS  = SQ_W / 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 56;

  localparam logic [GRAV_W-1:0]   GRAV_RESET   = 13'd2470;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd655;

  localparam int VEL_MAX = 65535;
  localparam int VEL_MIN = -65536;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRAVITY,
    CFG_PERIOD
  } cfg_idx_e;

  typedef struct packed {
    logic  smooth_en;  // request accepted: update the smoothing filters
    logic  sq_en;
    logic  sq_clr;
    axis_e sq_axis;
    logic  sqrt_init;
    logic  sqrt_step;
    logic  corr_en;    // correct, update ring and sum, start divider
    logic  div_step;
    logic  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// File: sv/imuamv_ctrl.sv
// Sequencer: steps the datapath through squaring, root, ring update and mean.
// Depends on imuamv_pkg.
module imuamv_ctrl import imuamv_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam int unsigned CNT_W = $clog2(ROOT_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_X,
    ST_SQ_Y,
    ST_SQ_Z,
    ST_SQRT,
    ST_CORR,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_SQ_X;
        end
        ST_SQ_X: state_q <= ST_SQ_Y;
        ST_SQ_Y: state_q <= ST_SQ_Z;
        ST_SQ_Z: begin
          cnt_q   <= CNT_W'(ROOT_STEPS - 1);
          state_q <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt_q == '0) state_q <= ST_CORR;
          else             cnt_q   <= cnt_q - 1'b1;
        end
        ST_CORR: state_q <= ST_DIV;
        ST_DIV:  state_q <= ST_FIN;
        ST_FIN: begin
          if (!stat_i.out_full) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    cmd_o      = '0;
    cmd_o.sq_axis = AXIS_X;
    case (state_q)
      ST_IDLE: cmd_o.smooth_en = in_valid_i;
      ST_SQ_X: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_clr = 1'b1;
      end
      ST_SQ_Y: begin
        cmd_o.sq_en   = 1'b1;
        cmd_o.sq_axis = AXIS_Y;
      end
      ST_SQ_Z: begin
        cmd_o.sq_en     = 1'b1;
        cmd_o.sq_axis   = AXIS_Z;
        cmd_o.sqrt_init = 1'b1;
      end
      ST_SQRT: cmd_o.sqrt_step = 1'b1;
      ST_CORR: cmd_o.corr_en   = 1'b1;
      ST_DIV:  cmd_o.div_step  = 1'b1;
      ST_FIN:  cmd_o.out_load  = !stat_i.out_full;
      default: ;
    endcase
  end

endmodule

// File: sv/imuamv_dp.sv
// Datapath: smoothing, shared squarer, bit-serial root, ring and running sum,
// reciprocal-multiply divide by the window length, velocity and output register.
// Depends on imuamv_pkg.
module imuamv_dp import imuamv_pkg::*; #(
  parameter int unsigned WINDOW      = 15,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_cmd_t                  cmd_i,
  output dp_stat_t                 stat_o,
  input  logic signed [ACC_W-1:0]  accel_x_i,
  input  logic signed [ACC_W-1:0]  accel_y_i,
  input  logic signed [ACC_W-1:0]  accel_z_i,
  input  logic [GRAV_W-1:0]        gravity_offset_i,
  input  logic [PERIOD_W-1:0]      sample_period_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [MAG_W-1:0]  corrected_magnitude_o,
  output logic signed [MAG_W-1:0]  filtered_mean_o,
  output logic signed [MAG_W-1:0]  velocity_o
);

  localparam int unsigned SUM_W    = MAG_W + $clog2(WINDOW);
  localparam int unsigned IDX_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned PROD_W   = MAG_W + PERIOD_W + 1;
  localparam int unsigned RECIP_SH = SUM_W + $clog2(WINDOW);
  localparam int unsigned QPROD_W  = SUM_W + RECIP_SH + 1;

  localparam logic signed [PROD_W-1:0] VMAX_P = PROD_W'(VEL_MAX);
  localparam logic signed [PROD_W-1:0] VMIN_P = PROD_W'(VEL_MIN);
  // ceil-style reciprocal of WINDOW, exact for any SUM_W-bit dividend
  localparam logic [RECIP_SH:0] RECIP =
    (RECIP_SH + 1)'((64'd1 << RECIP_SH) / 64'(WINDOW) + 64'd1);

  function automatic logic signed [ACC_W-1:0] halve(input logic signed [ACC_W-1:0] a,
                                                   input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    return s[ACC_W:1];
  endfunction

  // exponential smoothing
  logic signed [ACC_W-1:0] smooth_x_q, smooth_y_q, smooth_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_x_q <= '0;
      smooth_y_q <= '0;
      smooth_z_q <= '0;
    end else if (cmd_i.smooth_en) begin
      smooth_x_q <= halve(accel_x_i, smooth_x_q);
      smooth_y_q <= halve(accel_y_i, smooth_y_q);
      smooth_z_q <= halve(accel_z_i, smooth_z_q);
    end
  end

  // one squarer, one axis a cycle
  logic signed [ACC_W-1:0]   sq_op;
  logic signed [2*ACC_W-1:0] sq_full;
  logic [SQ_W-1:0]           acc_q, acc_d;

  always_comb begin
    case (cmd_i.sq_axis)
      AXIS_X:  sq_op = smooth_x_q;
      AXIS_Y:  sq_op = smooth_y_q;
      AXIS_Z:  sq_op = smooth_z_q;
      default: sq_op = smooth_x_q;
    endcase
  end

  assign sq_full = sq_op * sq_op;
  assign acc_d   = (cmd_i.sq_clr ? '0 : acc_q) + SQ_W'($unsigned(sq_full));

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_en) acc_q <= acc_d;
  end

  // floor square root, two radicand bits a step
  logic [SQ_W-1:0]   rad_q;
  logic [RREM_W-1:0] rrem_q;
  logic [ROOT_W-1:0] root_q;
  logic [RREM_W+1:0] rrem_sh, trial;

  assign rrem_sh = {rrem_q, rad_q[SQ_W-1 -: 2]};
  assign trial   = (RREM_W + 2)'({root_q, 2'b01});

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q  <= acc_d;
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= rad_q << 2;
      if (rrem_sh >= trial) begin
        rrem_q <= RREM_W'(rrem_sh - trial);
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rrem_q <= RREM_W'(rrem_sh);
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  // gravity correction, ring and running sum
  logic signed [MAG_W-1:0] corr_d, corr_q, old_val;
  logic [MAG_W-1:0]        ring_mem [WINDOW];
  logic [MAG_W-1:0]        ring_rd_q;
  logic [WINDOW-1:0]       ring_vld_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  assign corr_d  = $signed({1'b0, root_q} - MAG_W'(gravity_offset_i));
  assign old_val = ring_vld_q[idx_q] ? $signed(ring_rd_q) : '0;
  assign sum_d   = sum_q + SUM_W'(corr_d) - SUM_W'(old_val);

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr_en) ring_mem[idx_q] <= corr_d;
    ring_rd_q <= ring_mem[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_vld_q <= '0;
      idx_q      <= '0;
      sum_q      <= '0;
    end else if (cmd_i.corr_en) begin
      ring_vld_q[idx_q] <= 1'b1;
      idx_q <= (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr_en) corr_q <= corr_d;
  end

  // velocity from the mean held before this sample
  logic signed [MAG_W-1:0]  last_mean_q;
  logic signed [PROD_W-1:0] prod_q, vel_sh;
  logic signed [MAG_W-1:0]  vel_sat;

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr_en) prod_q <= last_mean_q * $signed({1'b0, sample_period_i});
  end

  assign vel_sh = prod_q >>> SAMPLE_BITS;

  always_comb begin
    if (vel_sh > VMAX_P)      vel_sat = VMAX_P[MAG_W-1:0];
    else if (vel_sh < VMIN_P) vel_sat = VMIN_P[MAG_W-1:0];
    else                      vel_sat = vel_sh[MAG_W-1:0];
  end

  // mean: |sum| / WINDOW by reciprocal multiply; a negative sum is biased by
  // WINDOW-1 first so the truncated quotient rounds toward minus infinity
  logic                    neg_q;
  logic [SUM_W-1:0]        dvd_q, quot_q, mean_full;
  logic [QPROD_W-1:0]      qprod;
  logic signed [MAG_W-1:0] mean;

  assign qprod = QPROD_W'(dvd_q) * QPROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.corr_en) begin
      neg_q <= sum_d[SUM_W-1];
      dvd_q <= sum_d[SUM_W-1] ? SUM_W'(-sum_d) + SUM_W'(WINDOW - 1) : SUM_W'(sum_d);
    end
    if (cmd_i.div_step) quot_q <= qprod[RECIP_SH +: SUM_W];
  end

  assign mean_full = neg_q ? -quot_q : quot_q;
  assign mean      = $signed(mean_full[MAG_W-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) last_mean_q <= '0;
    else if (cmd_i.out_load) last_mean_q <= mean;
  end

  // output register
  logic                    out_valid_q;
  logic signed [MAG_W-1:0] out_mag_q, out_mean_q, out_vel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)                       out_valid_q <= 1'b0;
    else if (cmd_i.out_load)           out_valid_q <= 1'b1;
    else if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_mag_q  <= corr_q;
      out_mean_q <= mean;
      out_vel_q  <= vel_sat;
    end
  end

  assign stat_o.out_full       = out_valid_q;
  assign out_valid_o           = out_valid_q;
  assign corrected_magnitude_o = out_mag_q;
  assign filtered_mean_o       = out_mean_q;
  assign velocity_o            = out_vel_q;

endmodule

// File: sv/imu_accel_magnitude_velocity.sv
// Acceleration magnitude, moving average and velocity; top level over
// imuamv_ctrl and imuamv_dp, uses imuamv_pkg.
// From request to result: three squaring steps, the 16-step root,
// correction, one reciprocal-multiply step for the mean and the output load.
// A new request is taken only once the last one is through; a waiting result also stalls input.
// Reset clears filters, ring (valid bits), running sum, index, last mean; config to defaults.
module imu_accel_magnitude_velocity import imuamv_pkg::*; #(
  parameter int unsigned WINDOW      = 15,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // request stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // accel_x, accel_y, accel_z
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // corrected_magnitude, filtered_mean,
                                                 // velocity, 5 zero bits
  // register writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  // config registers; writes always taken, only expected while idle
  logic [GRAV_W-1:0]   gravity_offset_q;
  logic [PERIOD_W-1:0] sample_period_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gravity_offset_q <= GRAV_RESET;
      sample_period_q  <= PERIOD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GRAVITY: gravity_offset_q <= cfg_data_i[GRAV_W-1:0];
        CFG_PERIOD:  sample_period_q  <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [MAG_W-1:0] corrected_magnitude, filtered_mean, velocity;

  imuamv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // samples are sampled by the datapath on the accepting edge only
  imuamv_dp #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .stat_o                (stat),
    .accel_x_i             ($signed(s_axis_tdata[ACC_W-1:0])),
    .accel_y_i             ($signed(s_axis_tdata[2*ACC_W-1:ACC_W])),
    .accel_z_i             ($signed(s_axis_tdata[3*ACC_W-1:2*ACC_W])),
    .gravity_offset_i      (gravity_offset_q),
    .sample_period_i       (sample_period_q),
    .out_valid_o           (m_axis_tvalid),
    .out_ready_i           (m_axis_tready),
    .corrected_magnitude_o (corrected_magnitude),
    .filtered_mean_o       (filtered_mean),
    .velocity_o            (velocity)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 3 * MAG_W)'(0), velocity, filtered_mean,
                         corrected_magnitude};

endmodule

// File: verif/imuamv_motion_checker.sv
`timescale 1ns / 100ps
// Scoreboard for imu_accel_magnitude_velocity: watches the request, result and register
// channels, predicts each result and compares it. Depends on imuamv_pkg.
module imuamv_motion_checker import imuamv_pkg::*; #(
  parameter int unsigned WINDOW      = 15,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     err_count_o,
  output int                     pending_o
);

  localparam int WIN     = WINDOW;  // signed copy, keeps the floor division signed
  localparam int MSG_CAP = 40;

  // same layout as the low bits of m_axis_tdata
  typedef struct packed {
    logic signed [MAG_W-1:0] velocity;
    logic signed [MAG_W-1:0] mean;
    logic signed [MAG_W-1:0] magnitude;
  } motion_t;

  motion_t                 expected_motion_q[$];
  logic [GRAV_W-1:0]       grav_q8;
  logic [PERIOD_W-1:0]     period_q16;
  logic signed [ACC_W-1:0] smooth [3];
  int                      ring [WIN];
  int                      ring_sum;
  int                      ring_pos;
  int                      prev_mean;

  task automatic flag_mismatch(input string what);
    if (err_count_o < MSG_CAP) $display("[%0t] result mismatch: %s", $realtime, what);
    err_count_o++;
  endtask

  // Advances the filter, ring and mean by one request and returns the result it gives.
  function automatic motion_t predict_motion(input logic [IN_TDATA_W-1:0] req);
    logic signed [ACC_W:0] pair;
    longint                sq_sum;
    longint                root;
    longint                trial;
    longint                vel;
    int                    corrected;
    int                    mean_now;
    int                    a;
    int                    k;
    motion_t               res;
    sq_sum = 0;
    for (a = 0; a < 3; a++) begin
      pair     = $signed(req[a*ACC_W +: ACC_W]) + smooth[a];
      smooth[a] = pair[ACC_W:1];  // floor of half the sum
      sq_sum   += longint'(smooth[a]) * longint'(smooth[a]);
    end
    // floor square root, one bit at a time from the top
    root = 0;
    for (k = ROOT_W - 1; k >= 0; k--) begin
      trial = root | (longint'(1) << k);
      if (trial * trial <= sq_sum) root = trial;
    end
    corrected = int'(root) - int'(grav_q8);

    // velocity uses the mean held before this request
    vel = (longint'(prev_mean) * longint'(period_q16)) >>> SAMPLE_BITS;
    if (vel > VEL_MAX) vel = VEL_MAX;
    if (vel < VEL_MIN) vel = VEL_MIN;

    ring_sum       = ring_sum - ring[ring_pos] + corrected;
    ring[ring_pos] = corrected;
    ring_pos       = (ring_pos == WIN - 1) ? 0 : ring_pos + 1;
    if (ring_sum >= 0) mean_now = ring_sum / WIN;
    else               mean_now = -((-ring_sum + WIN - 1) / WIN);
    prev_mean = mean_now;

    res.magnitude = corrected[MAG_W-1:0];
    res.mean      = mean_now[MAG_W-1:0];
    res.velocity  = vel[MAG_W-1:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    motion_t got;
    motion_t want;
    if (!rst_ni) begin
      expected_motion_q.delete();
      grav_q8     = GRAV_RESET;
      period_q16  = PERIOD_RESET;
      smooth      = '{default: '0};
      ring        = '{default: 0};
      ring_sum    = 0;
      ring_pos    = 0;
      prev_mean   = 0;
      err_count_o = 0;
      pending_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_GRAVITY: grav_q8    = cfg_data_i[GRAV_W-1:0];
          CFG_PERIOD:  period_q16 = cfg_data_i[PERIOD_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[3*MAG_W-1:0];
        if (expected_motion_q.size() == 0) begin
          flag_mismatch("result with no request outstanding");
        end else begin
          want = expected_motion_q.pop_front();
          if (got.magnitude !== want.magnitude)
            flag_mismatch($sformatf("magnitude %0d, want %0d", got.magnitude, want.magnitude));
          if (got.mean !== want.mean)
            flag_mismatch($sformatf("mean %0d, want %0d", got.mean, want.mean));
          if (got.velocity !== want.velocity)
            flag_mismatch($sformatf("velocity %0d, want %0d", got.velocity, want.velocity));
          if (m_axis_tdata[OUT_TDATA_W-1:3*MAG_W] !== '0)
            flag_mismatch("padding bits not zero");
        end
      end
      if (s_axis_tvalid && s_axis_tready) expected_motion_q.push_back(predict_motion(s_axis_tdata));
      pending_o = expected_motion_q.size();
    end
  end

endmodule

// File: verif/imu_accel_magnitude_velocity_test.sv
`timescale 1ns / 100ps
// Testbench top for imu_accel_magnitude_velocity: clock, reset, request and register
// stimulus, result back-pressure and verdict. Depends on imuamv_pkg, imuamv_motion_checker.
module imu_accel_magnitude_velocity_test import imuamv_pkg::*; ();

  localparam int HALF_PERIOD   = 4;
  localparam int CYCLE_LIMIT   = 1_000_000;  // far beyond the slowest legal run
  localparam int SETTLE_CYCLES = 60;         // more than one request latency
  localparam int HOLD_CYCLES   = 400;        // long result hold-off
  localparam int IDLE_PCT      = 13;
  localparam int MAX_GAP       = 48;         // sender gaps up to past one latency
  localparam int PHASE_ITEMS   = 445;
  localparam int QUIET_ITEMS   = 150;        // stretch with no idling on either side
  localparam int REST_Z        = 2512;       // roughly 1 g on z, Q7.8

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = CFG_GRAVITY;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  int mismatch_count;
  int result_backlog;
  int cycle_count;
  bit steady   = 1'b0;  // no idling on either side while set
  bit hold_req = 1'b0;  // asks the result side for one long hold-off

  always #HALF_PERIOD clk_i = ~clk_i;

  imu_accel_magnitude_velocity uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  imuamv_motion_checker motion_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .err_count_o   (mismatch_count),
    .pending_o     (result_backlog)
  );

  // Result side: random back-pressure, or one long hold-off counted here while the
  // sender keeps offering, so the block fills and stalls its request input.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Offers one request and returns at the edge that takes it. tvalid is left high so
  // back-to-back requests never lower and raise it in the same step.
  task automatic offer_sample(input logic [ACC_W-1:0] ax, input logic [ACC_W-1:0] ay,
                              input logic [ACC_W-1:0] az);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {az, ay, ax};
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Sender pause: stop offering and wait until every result has come back.
  task automatic await_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (result_backlog != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic await_cfg_accept();
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Writes both registers back to back; spare bits above the gravity field are noise
  task automatic set_config(input logic [GRAV_W-1:0] grav, input logic [PERIOD_W-1:0] period);
    logic [CFG_DATA_W-1:0] word;
    word              = CFG_DATA_W'($urandom);
    word[GRAV_W-1:0]  = grav;
    cfg_valid_i      <= 1'b1;
    cfg_index_i      <= CFG_GRAVITY;
    cfg_data_i       <= word;
    await_cfg_accept();
    cfg_index_i      <= CFG_PERIOD;
    cfg_data_i       <= period;
    await_cfg_accept();
    cfg_valid_i      <= 1'b0;
  endtask

  function automatic logic [ACC_W-1:0] rail_value();
    case ($urandom_range(3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      default: return '0;
    endcase
  endfunction

  // Mostly a device near rest (gravity on z, possibly upside down, small noise),
  // plus full-range noise, rail values and runs of repeated samples.
  task automatic run_random(input int count);
    logic [ACC_W-1:0] ax;
    logic [ACC_W-1:0] ay;
    logic [ACC_W-1:0] az;
    int               roll;
    int               n;
    ax = '0;
    ay = '0;
    az = ACC_W'(REST_Z);
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 40) begin
        ax = ACC_W'(int'($urandom_range(1200)) - 600);
        ay = ACC_W'(int'($urandom_range(1200)) - 600);
        az = ACC_W'(REST_Z + int'($urandom_range(1024)) - 512);
        if ($urandom_range(9) == 0) az = -az;
      end else if (roll < 65) begin
        ax = ACC_W'($urandom);
        ay = ACC_W'($urandom);
        az = ACC_W'($urandom);
      end else if (roll < 80) begin
        ax = rail_value();
        ay = rail_value();
        az = rail_value();
      end
      // otherwise repeat the last sample: a steady run through the window
      offer_sample(ax, ay, az);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset register values: zero input, positive and negative rails held
    // for three requests each, mixed signs, -1 for the round-down of halving, single
    // LSBs on each axis, then a rest run during which the ring index wraps the window
    offer_sample('0, '0, '0);
    repeat (3) offer_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    repeat (3) offer_sample(16'h8000, 16'h8000, 16'h8000);
    offer_sample(16'h7FFF, 16'h8000, '0);
    repeat (2) offer_sample(16'hFFFF, 16'hFFFF, 16'hFFFF);
    offer_sample(16'h0001, '0, '0);
    offer_sample('0, 16'h0001, '0);
    offer_sample('0, '0, 16'h0001);
    repeat (10) offer_sample('0, '0, ACC_W'(REST_Z));
    await_results();

    // extremes: no gravity removed, longest period
    set_config('0, '1);
    steady = 1'b1;
    run_random(QUIET_ITEMS);
    steady = 1'b0;
    run_random(PHASE_ITEMS - QUIET_ITEMS);
    await_results();

    // other extremes: largest offset, zero period; long result hold-off mid-phase
    set_config('1, '0);
    run_random(80);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS - 80);
    await_results();

    set_config(GRAV_W'($urandom), PERIOD_W'($urandom));
    run_random(PHASE_ITEMS);
    await_results();

    // back to the reset values, with a second hold-off
    set_config(GRAV_RESET, PERIOD_RESET);
    run_random(40);
    hold_req = 1'b1;
    run_random(PHASE_ITEMS - 40);
    await_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

endmodule
